// ===== rtl/mprl_pkg.sv =====
// Shared constants, types and codes for the peak and RMS level meter.
package mprl_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int BAR_SEGMENTS = 20;
    localparam int SAMPLE_W     = 32;
    localparam int CH_W         = 3;
    localparam int WIN_W        = 17;
    localparam int LOG_W        = 22;
    localparam int LEVEL_W      = 12;
    localparam int BAR_W        = 5;
    localparam int PROD_W       = 48;

    localparam logic [22:0] PEAK_K = 23'd3945660;
    localparam logic [22:0] RMS_K  = 23'd1972830;
    localparam logic signed [15:0] SILENT_TENTHS = -16'sd1200;
    localparam logic signed [15:0] BAR_FLOOR     = -16'sd900;
    localparam int BAR_SHIFT = 26;
    localparam int BAR_RECIP = (2**BAR_SHIFT + 899) / 900;

    typedef logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0] t_frame;

    typedef struct packed {
        logic [CH_W-1:0]           channel;
        logic signed [LEVEL_W-1:0] peak_tenths_db;
        logic signed [LEVEL_W-1:0] rms_tenths_db;
        logic [BAR_W-1:0]          peak_bar;
        logic [BAR_W-1:0]          rms_bar;
        logic                      last;
    } t_result;

    typedef struct packed {
        logic             start;
        logic [63:0]      x;
    } t_log_req;

    typedef struct packed {
        logic             done;
        logic [LOG_W-1:0] value;
    } t_log_rsp;

endpackage

// ===== rtl/mprl_front.sv =====
// Input frame queue that accepts transactions and hands frames to the back end.
module mprl_front
    import mprl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    output logic   o_full,
    output logic   o_valid,
    output t_frame o_frame,
    input  logic   i_pop
);

    t_frame     r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       n_push;
    logic       n_pop;

    // The queue reports full while reset is held so that no transaction is taken then.
    assign o_full  = (r_count == 2'd2) || !i_rst_n;
    assign o_valid = (r_count != 2'd0);
    assign o_frame = r_mem[r_rd];
    assign n_push  = i_push && !o_full;
    assign n_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (n_push) begin
                r_wr <= ~r_wr;
            end
            if (n_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, n_push} - {1'b0, n_pop};
        end
    end

endmodule

// ===== rtl/mprl_log2.sv =====
// Iterative log2 in Q16: six normalizing steps, then sixteen squarings.
module mprl_log2
    import mprl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_log_req i_req,
    output t_log_rsp o_rsp
);

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_NORM = 3'b010,
        L_SQ   = 3'b100
    } t_lstate;

    t_lstate      r_state;
    logic [63:0]  r_x;
    logic [5:0]   r_msb;
    logic [2:0]   r_step;
    logic [3:0]   r_it;
    logic [31:0]  r_m;
    logic [15:0]  r_frac;
    logic         r_done;
    logic [5:0]   n_k;
    logic [63:0]  n_x;
    logic [5:0]   n_msb;
    logic [63:0]  n_sq;
    logic [32:0]  n_t;

    always_comb begin
        n_k   = 6'd32 >> r_step;
        n_x   = r_x;
        n_msb = r_msb;
        if ((r_x >> (7'd64 - {1'b0, n_k})) == 64'd0) begin
            n_x   = r_x << n_k;
            n_msb = r_msb - n_k;
        end
        n_sq = {32'd0, r_m} * {32'd0, r_m};
        n_t  = n_sq[63:31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                L_IDLE: begin
                    if (i_req.start) begin
                        r_x     <= i_req.x;
                        r_msb   <= 6'd63;
                        r_step  <= 3'd0;
                        r_state <= L_NORM;
                    end
                end
                L_NORM: begin
                    r_x    <= n_x;
                    r_msb  <= n_msb;
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd5) begin
                        r_m     <= n_x[63:32];
                        r_it    <= 4'd0;
                        r_frac  <= 16'd0;
                        r_state <= L_SQ;
                    end
                end
                L_SQ: begin
                    // A square at or above two sets the fraction bit and halves m.
                    if (n_t[32]) begin
                        r_m    <= n_t[32:1];
                        r_frac <= {r_frac[14:0], 1'b1};
                    end else begin
                        r_m    <= n_t[31:0];
                        r_frac <= {r_frac[14:0], 1'b0};
                    end
                    r_it <= r_it + 4'd1;
                    if (r_it == 4'd15) begin
                        r_done  <= 1'b1;
                        r_state <= L_IDLE;
                    end
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = {r_msb, r_frac};

endmodule

// ===== rtl/mprl_outq.sv =====
// Result queue of one window's worth of channel results.
module mprl_outq
    import mprl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_empty,
    output t_result o_data,
    input  logic    i_pop
);

    t_result       r_mem [8];
    logic [2:0]    r_wr;
    logic [2:0]    r_rd;
    logic [3:0]    r_count;
    logic          n_pop;

    assign o_empty = (r_count == 4'd0);
    assign o_data  = r_mem[r_rd];
    assign n_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 3'd0;
            r_rd    <= 3'd0;
            r_count <= 4'd0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 3'd1;
            end
            if (n_pop) begin
                r_rd <= r_rd + 3'd1;
            end
            r_count <= r_count + {3'd0, i_push} - {3'd0, n_pop};
        end
    end

endmodule

// ===== rtl/mprl_back.sv =====
// Back end: per-channel accumulation and the window-end dB conversion sequencer.
module mprl_back
    import mprl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [WIN_W-1:0] i_cfg_wdata,
    input  logic             i_fvalid,
    input  t_frame           i_frame,
    output logic             o_fpop,
    output t_log_req         o_lreq,
    input  t_log_rsp         i_lrsp,
    input  logic             i_oq_empty,
    output logic             o_push,
    output t_result          o_res
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_ACC    = 10'b0000000010,
        S_ACCEND = 10'b0000000100,
        S_WAITQ  = 10'b0000001000,
        S_LOGN   = 10'b0000010000,
        S_LOGP   = 10'b0000100000,
        S_LOGS   = 10'b0001000000,
        S_MUL    = 10'b0010000000,
        S_RND    = 10'b0100000000,
        S_PUSH   = 10'b1000000000
    } t_state;

    t_state                    r_state;
    logic [WIN_W-1:0]          r_win;
    logic [WIN_W-1:0]          r_fc;
    logic [WIN_W-1:0]          r_ncount;
    t_frame                    r_frame;
    logic [CH_W-1:0]           r_ch;
    logic [SAMPLE_W-1:0]       r_peak [NUM_CHANNELS];
    logic [63:0]               r_sum  [NUM_CHANNELS];
    logic                      r_pv;
    logic [CH_W-1:0]           r_pch;
    logic [31:0]               r_pmag;
    logic [47:0]               r_psq;
    logic                      r_lbusy;
    logic [LOG_W-1:0]          r_ln;
    logic [LOG_W-1:0]          r_lp;
    logic [LOG_W-1:0]          r_ls;
    logic                      r_sp;
    logic                      r_ss;
    logic signed [PROD_W-1:0]  r_prodp;
    logic signed [PROD_W-1:0]  r_prods;
    logic signed [LEVEL_W-1:0] r_pk;
    logic signed [LEVEL_W-1:0] r_rm;

    logic [31:0]               n_smp;
    logic [31:0]               n_mag;
    logic [23:0]               n_s;
    logic [WIN_W-1:0]          n_win;
    logic [WIN_W-1:0]          n_fc;
    logic signed [23:0]        n_dp;
    logic signed [24:0]        n_ds;
    logic                      n_inlog;
    logic [BAR_W-1:0]          n_pbar;
    logic [BAR_W-1:0]          n_rbar;
    logic                      n_last;

    function automatic logic signed [LEVEL_W-1:0] round_clamp(
        input logic signed [PROD_W-1:0] prod,
        input logic                     silent
    );
        logic signed [PROD_W-1:0] t;
        logic signed [15:0]       r;
        t = prod + 48'sd2147483648;
        r = t[47:32];
        if (silent || r < SILENT_TENTHS) begin
            r = SILENT_TENTHS;
        end
        if (r > 16'sd0) begin
            r = 16'sd0;
        end
        return r[LEVEL_W-1:0];
    endfunction

    function automatic logic [BAR_W-1:0] bar_fill(input logic signed [LEVEL_W-1:0] lvl);
        logic signed [15:0] d;
        logic [15:0]        x;
        logic [15:0]        y;
        logic [33:0]        q;
        d = {{(16-LEVEL_W){lvl[LEVEL_W-1]}}, lvl};
        if (d < BAR_FLOOR) begin
            d = BAR_FLOOR;
        end
        x = 16'(d - BAR_FLOOR);
        y = 16'(x * BAR_SEGMENTS);
        // Division by 900 through a scaled reciprocal; exact over this range.
        q = {18'd0, y} * 34'(BAR_RECIP);
        return q[BAR_SHIFT +: BAR_W];
    endfunction

    assign n_smp = r_frame[r_ch];
    assign n_mag = n_smp[31] ? (~n_smp + 32'd1) : n_smp;
    assign n_s   = n_mag[31:8];
    assign n_win = (r_win == '0) ? WIN_W'(1) : r_win;
    assign n_fc  = r_fc + WIN_W'(1);
    assign n_dp  = $signed({2'b00, r_lp}) - 24'sd2031616;
    assign n_ds  = $signed({3'b000, r_ls}) - $signed({3'b000, r_ln}) - 25'sd3014656;
    assign n_inlog = (r_state == S_LOGN) || (r_state == S_LOGP) || (r_state == S_LOGS);
    assign n_pbar = bar_fill(r_pk);
    assign n_rbar = bar_fill(r_rm);
    assign n_last = (r_ch == CH_W'(NUM_CHANNELS - 1));

    always_comb begin
        o_lreq.start = n_inlog && !r_lbusy;
        case (r_state)
            S_LOGN:  o_lreq.x = {{(64-WIN_W){1'b0}}, r_ncount};
            S_LOGP:  o_lreq.x = {32'd0, r_peak[r_ch]};
            default: o_lreq.x = r_sum[r_ch];
        endcase
    end

    assign o_fpop = (r_state == S_IDLE) && i_fvalid;
    assign o_push = (r_state == S_PUSH);
    assign o_res.channel        = r_ch;
    assign o_res.peak_tenths_db = r_pk;
    assign o_res.rms_tenths_db  = r_rm;
    assign o_res.peak_bar       = n_pbar;
    assign o_res.rms_bar        = n_rbar;
    assign o_res.last           = n_last;

    always_ff @(posedge i_clk) begin
        if (r_state == S_ACC) begin
            r_pmag <= n_mag;
            r_psq  <= {24'd0, n_s} * {24'd0, n_s};
            r_pch  <= r_ch;
        end
        if (o_fpop) begin
            r_frame <= i_frame;
        end
        if (r_state == S_MUL) begin
            r_prodp <= PROD_W'(n_dp) * $signed({1'b0, PEAK_K});
            r_prods <= PROD_W'(n_ds) * $signed({1'b0, RMS_K});
            r_sp    <= (r_peak[r_ch] == '0);
            r_ss    <= (r_sum[r_ch] == '0);
        end
        if (r_state == S_RND) begin
            r_pk <= round_clamp(r_prodp, r_sp);
            r_rm <= round_clamp(r_prods, r_ss);
        end
        if (i_lrsp.done) begin
            case (r_state)
                S_LOGN:  r_ln <= i_lrsp.value;
                S_LOGP:  r_lp <= i_lrsp.value;
                default: r_ls <= i_lrsp.value;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_win    <= WIN_W'(2400);
            r_fc     <= '0;
            r_ncount <= '0;
            r_ch     <= '0;
            r_pv     <= 1'b0;
            r_lbusy  <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_peak[c] <= '0;
                r_sum[c]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_win <= i_cfg_wdata;
            end
            r_pv <= (r_state == S_ACC);
            if (r_pv) begin
                if (r_pmag > r_peak[r_pch]) begin
                    r_peak[r_pch] <= r_pmag;
                end
                r_sum[r_pch] <= r_sum[r_pch] + {16'd0, r_psq};
            end
            if (o_lreq.start) begin
                r_lbusy <= 1'b1;
            end else if (i_lrsp.done) begin
                r_lbusy <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_fvalid) begin
                        r_ch    <= '0;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (n_last) begin
                        r_ch    <= '0;
                        r_state <= S_ACCEND;
                    end else begin
                        r_ch <= r_ch + CH_W'(1);
                    end
                end
                S_ACCEND: begin
                    // A zero window register behaves as a window of one frame.
                    if (n_fc >= n_win) begin
                        r_fc     <= '0;
                        r_ncount <= n_fc;
                        r_state  <= S_WAITQ;
                    end else begin
                        r_fc    <= n_fc;
                        r_state <= S_IDLE;
                    end
                end
                S_WAITQ: begin
                    if (i_oq_empty) begin
                        r_state <= S_LOGN;
                    end
                end
                S_LOGN: begin
                    if (i_lrsp.done) begin
                        r_state <= S_LOGP;
                    end
                end
                S_LOGP: begin
                    if (i_lrsp.done) begin
                        r_state <= S_LOGS;
                    end
                end
                S_LOGS: begin
                    if (i_lrsp.done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    r_peak[r_ch] <= '0;
                    r_sum[r_ch]  <= '0;
                    if (n_last) begin
                        r_ch    <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_ch    <= r_ch + CH_W'(1);
                        r_state <= S_LOGP;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_wait_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAITQ) && !i_oq_empty |=> (r_state == S_WAITQ))
        else $error("conversion started while results were still queued");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_res.last |=> (r_state == S_IDLE) && (r_ch == '0))
        else $error("window did not close after the last channel result");

    a_pop_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fpop |=> (r_state == S_ACC) && (r_ch == '0))
        else $error("frame taken without starting accumulation");

    a_log_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_lrsp.done |-> r_lbusy && n_inlog)
        else $error("log result arrived with no request outstanding");

endmodule

// ===== rtl/multichannel_peak_rms_level_meter.sv =====
// Top level of the eight-channel peak and RMS level meter.
//
// Input channel: one transaction is one frame of eight signed 32-bit samples,
// taken when push is high and full is low. A two-frame queue sits in front.
// Each frame is accumulated one channel per cycle through a single 24x24
// squaring multiplier, after the idle state that takes the frame and before
// an end state that counts it. After the configured number of frames the
// block converts every channel to tenths of dBFS with an iterative log2 unit.
// New frames wait in the input queue during the conversion. Results leave
// through an eight-entry queue: the oldest is on the o_ ports while empty is
// low and moves on at pop. Channel 7 carries last.
// If the receiver stalls, a finished window waits in the result queue and the
// next window's conversion holds until that queue has drained.
// Write i_cfg_wdata with i_cfg_we to set the window length while idle.
// Synchronous reset empties both queues, clears all accumulators and the frame
// count, and sets the window to 2400 frames.
module multichannel_peak_rms_level_meter
    import mprl_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [WIN_W-1:0]          i_cfg_wdata,
    input  logic                      push,
    output logic                      full,
    input  logic signed [31:0]        i_sample_ch0,
    input  logic signed [31:0]        i_sample_ch1,
    input  logic signed [31:0]        i_sample_ch2,
    input  logic signed [31:0]        i_sample_ch3,
    input  logic signed [31:0]        i_sample_ch4,
    input  logic signed [31:0]        i_sample_ch5,
    input  logic signed [31:0]        i_sample_ch6,
    input  logic signed [31:0]        i_sample_ch7,
    output logic                      empty,
    input  logic                      pop,
    output logic [CH_W-1:0]           o_channel,
    output logic signed [LEVEL_W-1:0] o_peak_tenths_db,
    output logic signed [LEVEL_W-1:0] o_rms_tenths_db,
    output logic [BAR_W-1:0]          o_peak_bar,
    output logic [BAR_W-1:0]          o_rms_bar,
    output logic                      o_last
);

    t_frame   w_in_frame;
    t_frame   w_frame;
    logic     w_fvalid;
    logic     w_fpop;
    t_log_req w_lreq;
    t_log_rsp w_lrsp;
    logic     w_oq_empty;
    logic     w_push;
    t_result  w_res;
    t_result  w_head;

    assign w_in_frame = {i_sample_ch7, i_sample_ch6, i_sample_ch5, i_sample_ch4,
                         i_sample_ch3, i_sample_ch2, i_sample_ch1, i_sample_ch0};

    mprl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (w_in_frame),
        .o_full  (full),
        .o_valid (w_fvalid),
        .o_frame (w_frame),
        .i_pop   (w_fpop)
    );

    mprl_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_lreq),
        .o_rsp   (w_lrsp)
    );

    mprl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fvalid    (w_fvalid),
        .i_frame     (w_frame),
        .o_fpop      (w_fpop),
        .o_lreq      (w_lreq),
        .i_lrsp      (w_lrsp),
        .i_oq_empty  (w_oq_empty),
        .o_push      (w_push),
        .o_res       (w_res)
    );

    mprl_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_empty (w_oq_empty),
        .o_data  (w_head),
        .i_pop   (pop)
    );

    assign empty            = w_oq_empty;
    assign o_channel        = w_head.channel;
    assign o_peak_tenths_db = w_head.peak_tenths_db;
    assign o_rms_tenths_db  = w_head.rms_tenths_db;
    assign o_peak_bar       = w_head.peak_bar;
    assign o_rms_bar        = w_head.rms_bar;
    assign o_last           = w_head.last;

endmodule
